// ===== rtl/core/acef_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package acef_pkg;

   // Sequence text buffer.
   localparam int SEQ_CHARS = 12;
   localparam int SEQ_IDX_W = $clog2(SEQ_CHARS);
   localparam int SEQ_LEN_W = $clog2(SEQ_CHARS + 1);

   // Queue between the parser and the result sequencer.
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] CHAR_ESC  = 8'd27;
   localparam logic [7:0] CHAR_OPEN = 8'h5B;
   localparam logic [7:0] CHAR_END  = 8'h6D;
   localparam logic [7:0] CHAR_NUL  = 8'h00;

   localparam logic [3:0] COLOR_DEFAULT = 4'd3;
   localparam logic [3:0] COLOR_GREY    = 4'd7;

   localparam logic KIND_CHAR  = 1'b0;
   localparam logic KIND_COLOR = 1'b1;

   // Color selector strings, left aligned and padded with spaces.
   localparam int SGR_COUNT = 8;
   localparam int SGR_MAX   = 11;

   localparam logic [0:SGR_COUNT-1][SGR_MAX*8-1:0] SGR_TEXT = '{
      "[39        ",
      "[38;5;252  ",
      "[38;5;31   ",
      "[38;5;70;01",
      "[38;5;246  ",
      "[38;5;214  ",
      "[38;5;67   ",
      "[38;5;68   "
   };

   localparam logic [0:SGR_COUNT-1][3:0] SGR_LEN = '{
      4'd3, 4'd9, 4'd8, 4'd11, 4'd9, 4'd9, 4'd8, 4'd8
   };

   localparam logic [0:SGR_COUNT-1][3:0] SGR_COLOR = '{
      4'd3, 4'd15, 4'd11, 4'd10, 4'd8, 4'd14, 4'd13, 4'd11
   };

   typedef enum logic [1:0] {
      PH_NORMAL,
      PH_ESC,
      PH_SEQ
   } phase_type;

   typedef logic [SEQ_CHARS-1:0][7:0] seq_text_type;

   // What one input byte asks the result side to send.
   typedef struct packed {
      logic       emit_char;
      logic [7:0] char_code;
      logic       emit_color;
      logic [3:0] color;
      logic       emit_grey;
   } cmd_type;

   typedef struct packed {
      logic    not_empty;
      logic    full;
      cmd_type head;
   } queue_status_type;

   // The first table entry whose length and text both match wins.
   function automatic logic [3:0] pick_color(input seq_text_type text,
                                             input logic [SEQ_LEN_W-1:0] len);
      logic [3:0] color;
      logic       same;
      color = COLOR_DEFAULT;
      for (int k = SGR_COUNT - 1; k >= 0; k--) begin
         same = (len == SEQ_LEN_W'(SGR_LEN[k]));
         for (int i = 0; i < SGR_MAX; i++) begin
            if (i < int'(SGR_LEN[k])) begin
               if (text[i] != SGR_TEXT[k][(SGR_MAX-1-i)*8 +: 8]) begin
                  same = 1'b0;
               end
            end
         end
         if (same) begin
            color = SGR_COLOR[k];
         end
      end
      return color;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/acef_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module acef_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             fire,
   input  wire logic [7:0]       in_byte,
   input  wire logic             in_last,
   input  wire logic             csr_write_enable,
   input  wire logic             csr_write_data,
   output acef_pkg::cmd_type     cmd,
   output logic                  push
);

   acef_pkg::phase_type                    phase_ff, phase_in;
   acef_pkg::phase_type                    eff_phase;
   logic [acef_pkg::SEQ_LEN_W-1:0]         len_ff, len_in, len_base;
   acef_pkg::seq_text_type                 text_ff;
   logic                                   color_enable_ff;
   logic                                   is_esc, is_open, is_end, append;

   always_comb begin
      is_esc  = (in_byte == acef_pkg::CHAR_ESC);
      is_open = !is_esc && (phase_ff == acef_pkg::PH_ESC) && (in_byte == acef_pkg::CHAR_OPEN);
      is_end  = !is_esc && (phase_ff == acef_pkg::PH_SEQ) && (in_byte == acef_pkg::CHAR_END);
      if (is_esc) begin
         eff_phase = acef_pkg::PH_ESC;
      end else if (is_open) begin
         eff_phase = acef_pkg::PH_SEQ;
      end else begin
         eff_phase = phase_ff;
      end
   end

   // Next state.
   always_comb begin
      phase_in = phase_ff;
      if (fire) begin
         if (in_last || is_end) begin
            phase_in = acef_pkg::PH_NORMAL;
         end else begin
            phase_in = eff_phase;
         end
      end
   end

   // Outputs and buffer updates. Opening bracket restarts the count; stale text beyond
   // the count is never compared, so the buffer itself needs no clearing.
   always_comb begin
      len_base = is_open ? '0 : len_ff;
      append   = (eff_phase == acef_pkg::PH_SEQ) && !is_end && (in_byte != acef_pkg::CHAR_NUL)
                 && (len_base < acef_pkg::SEQ_LEN_W'(acef_pkg::SEQ_CHARS));
      len_in   = len_ff;
      if (fire) begin
         if (in_last) begin
            len_in = '0;
         end else if (append) begin
            len_in = len_base + acef_pkg::SEQ_LEN_W'(1);
         end else begin
            len_in = len_base;
         end
      end
      cmd.emit_char  = (eff_phase == acef_pkg::PH_NORMAL);
      cmd.char_code  = in_byte;
      cmd.emit_color = is_end && color_enable_ff;
      cmd.color      = acef_pkg::pick_color(text_ff, len_ff);
      cmd.emit_grey  = in_last;
      push           = fire && (cmd.emit_char || cmd.emit_color || cmd.emit_grey);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= acef_pkg::PH_NORMAL;
         len_ff          <= '0;
         color_enable_ff <= 1'b1;
      end else begin
         phase_ff <= phase_in;
         len_ff   <= len_in;
         if (csr_write_enable) begin
            color_enable_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire && append) begin
         text_ff[len_base[acef_pkg::SEQ_IDX_W-1:0]] <= in_byte;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/acef_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module acef_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire acef_pkg::cmd_type    push_cmd,
   input  wire logic                 pop,
   output acef_pkg::queue_status_type status
);

   acef_pkg::cmd_type                    entry_ff [acef_pkg::QUEUE_DEPTH];
   logic [acef_pkg::QUEUE_PTR_W-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [acef_pkg::QUEUE_CNT_W-1:0]     count_ff, count_in;

   always_comb begin
      status.not_empty = (count_ff != '0);
      status.full      = (count_ff == acef_pkg::QUEUE_CNT_W'(acef_pkg::QUEUE_DEPTH));
      status.head      = entry_ff[rd_ptr_ff];
      count_in         = count_ff;
      if (push && !pop) begin
         count_in = count_ff + acef_pkg::QUEUE_CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - acef_pkg::QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + acef_pkg::QUEUE_PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + acef_pkg::QUEUE_PTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/acef_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module acef_back (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire acef_pkg::queue_status_type status,
   output logic                           pop,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic                           rsp_out_kind,
   output logic [7:0]                     rsp_out_char,
   output logic [3:0]                     rsp_out_color,
   output logic                           rsp_out_last
);

   logic       pend_char_ff, pend_color_ff, pend_grey_ff;
   logic       pend_char_in, pend_color_in, pend_grey_in;
   logic [7:0] char_ff;
   logic [3:0] color_ff;
   logic       busy, fire, load;

   always_comb begin
      busy = pend_char_ff || pend_color_ff || pend_grey_ff;
      fire = busy && !rsp_stall;

      // Results of one byte go out in order: character or color first, then grey.
      pend_char_in  = pend_char_ff;
      pend_color_in = pend_color_ff;
      pend_grey_in  = pend_grey_ff;
      if (fire) begin
         if (pend_char_ff) begin
            pend_char_in = 1'b0;
         end else if (pend_color_ff) begin
            pend_color_in = 1'b0;
         end else begin
            pend_grey_in = 1'b0;
         end
      end

      load = status.not_empty && !(pend_char_in || pend_color_in || pend_grey_in);
      pop  = load;
      if (load) begin
         pend_char_in  = status.head.emit_char;
         pend_color_in = status.head.emit_color;
         pend_grey_in  = status.head.emit_grey;
      end
   end

   always_comb begin
      rsp_valid     = busy;
      rsp_out_kind  = pend_char_ff ? acef_pkg::KIND_CHAR : acef_pkg::KIND_COLOR;
      rsp_out_char  = pend_char_ff ? char_ff : 8'd0;
      rsp_out_last  = !pend_char_ff && !pend_color_ff;
      if (pend_char_ff) begin
         rsp_out_color = 4'd0;
      end else if (pend_color_ff) begin
         rsp_out_color = color_ff;
      end else begin
         rsp_out_color = acef_pkg::COLOR_GREY;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_char_ff  <= 1'b0;
         pend_color_ff <= 1'b0;
         pend_grey_ff  <= 1'b0;
      end else begin
         pend_char_ff  <= pend_char_in;
         pend_color_ff <= pend_color_in;
         pend_grey_ff  <= pend_grey_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         char_ff  <= status.head.char_code;
         color_ff <= status.head.color;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/ansi_color_escape_filter.sv =====
// Channel   Direction  Handshake                 Payload
// req       in         req_valid / req_stall     req_in_byte, req_in_last
// rsp       out        rsp_valid / rsp_stall     rsp_out_kind, rsp_out_char, rsp_out_color,
//                                                rsp_out_last
// csr       in         csr_write_enable          csr_write_data (color enable)
//
// The parser takes one byte per cycle while req_stall is low; a byte that causes results
// is written to the command queue, then to the result sequencer's pending flags, before
// its first result is offered. The sequencer sends one result per cycle unless rsp_stall
// is high, so a byte with two results (color or character, then grey) occupies it for both.
// A four-entry command queue separates the two; req_stall rises only when it is full.
// Reset is synchronous and active high; it clears phase, length, queue and sets color enable.
`timescale 1ns / 1ps
`default_nettype none

module ansi_color_escape_filter (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_in_byte,
   input  wire logic       req_in_last,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic            rsp_out_kind,
   output logic [7:0]      rsp_out_char,
   output logic [3:0]      rsp_out_color,
   output logic            rsp_out_last,
   input  wire logic       csr_write_enable,
   input  wire logic       csr_write_data
);

   acef_pkg::cmd_type          cmd;
   acef_pkg::queue_status_type status;
   logic                       push, pop, req_fire;

   assign req_stall = status.full;
   assign req_fire  = req_valid && !req_stall;

   acef_front u_front (
      .clock            (clock),
      .reset            (reset),
      .fire             (req_fire),
      .in_byte          (req_in_byte),
      .in_last          (req_in_last),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .cmd              (cmd),
      .push             (push)
   );

   acef_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (cmd),
      .pop      (pop),
      .status   (status)
   );

   acef_back u_back (
      .clock         (clock),
      .reset         (reset),
      .status        (status),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_kind  (rsp_out_kind),
      .rsp_out_char  (rsp_out_char),
      .rsp_out_color (rsp_out_color),
      .rsp_out_last  (rsp_out_last)
   );

   // A character result never carries a color and never closes a document.
   a_char_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_out_kind == acef_pkg::KIND_CHAR) |-> (rsp_out_color == 4'd0)
      && !rsp_out_last)
      else $error("character result with color or last flag");

   // A color result carries no character.
   a_color_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_out_kind == acef_pkg::KIND_COLOR) |-> (rsp_out_char == 8'd0))
      else $error("color result with nonzero character");

   // A full queue implies the sequencer already holds work.
   a_full_busy: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("queue full while result side idle");

   // The last-document result always carries the grey reset color.
   a_last_grey: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_last |-> (rsp_out_color == acef_pkg::COLOR_GREY))
      else $error("last result without grey color");

endmodule

`default_nettype wire
